### rtl/vn2_pkg.sv
// shared types and constants for the fractal value noise block
`default_nettype none

package vn2_pkg;

    // default sizes
    localparam int MAX_OCT_DEF  = 16;
    localparam int WT_DEPTH_DEF = 1024;

    // weight entries are unsigned q1.16
    localparam int WT_W = 17;

    // lattice points hashed per octave (4 x 4 grid)
    localparam int HASH_POINTS = 16;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SEED   = 3'd0,
        CFG_RATIO  = 3'd1,
        CFG_OCT    = 3'd2,
        CFG_SHIFTX = 3'd3,
        CFG_SHIFTY = 3'd4
    } cfg_idx_t;

    // hash constants
    localparam logic [31:0] HASH_MUL_Y = 32'd57;
    localparam logic [31:0] HASH_C1    = 32'd15731;
    localparam logic [31:0] HASH_C2    = 32'd789221;
    localparam logic [31:0] HASH_C3    = 32'd1376312589;
    localparam logic signed [31:0] Q30_ONE_S = 32'sh4000_0000;

    // weight table generation constants
    localparam longint HALF_PI_Q30 = 64'd1686629713;
    localparam logic [30:0] Q30_ONE_U = 31'h4000_0000;
    localparam logic [6:0] DENOM [5] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [32:0] RECIP [5] = '{
        33'((64'd1 << 35) / 64'd110),
        33'((64'd1 << 35) / 64'd72),
        33'((64'd1 << 35) / 64'd42),
        33'((64'd1 << 35) / 64'd20),
        33'((64'd1 << 35) / 64'd6)
    };
    localparam logic [61:0] SQ_ROUND = 62'd1 << 43;

    // blend operand select
    typedef enum logic [1:0] {
        BL_TOP = 2'd0,
        BL_BOT = 2'd1,
        BL_FIN = 2'd2
    } blend_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       setup;
        logic       rd_y;
        logic       ld_wx;
        logic       ld_wy;
        logic       hash_vld;
        logic [3:0] hash_tag;
        logic       smooth_row;
        logic       smooth_col;
        blend_t     blend_sel;
        logic       blend_a;
        logic       blend_b;
        logic       accum;
        logic       finish;
    } cmd_t;

    // datapath status
    typedef struct packed {
        logic more;
    } stat_t;

endpackage

`default_nettype wire

### rtl/vn2_ram.sv
// generic single write port ram with registered read
`default_nettype none

module vn2_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/vn2_wtab_fill.sv
// builds the cosine weight table into ram after reset, one entry at a time
`default_nettype none

module vn2_wtab_fill
    import vn2_pkg::*;
#(
    parameter int WEIGHT_DEPTH = WT_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    output logic                                 we,
    output logic [$clog2(WEIGHT_DEPTH)-1:0]      waddr,
    output logic [WT_W-1:0]                      wdata,
    output logic                                 fill_done
);

    localparam int AW = $clog2(WEIGHT_DEPTH);
    localparam int RW = AW + 2;
    localparam logic [30:0]   TH_STEP = 31'(HALF_PI_Q30 / WEIGHT_DEPTH);
    localparam logic [RW-1:0] TH_REM  = RW'(HALF_PI_Q30 % WEIGHT_DEPTH);
    localparam logic [RW-1:0] DEPTH_R = RW'(WEIGHT_DEPTH);

    typedef enum logic [6:0] {
        FL_T2   = 7'b0000001,
        FL_MUL  = 7'b0000010,
        FL_REC  = 7'b0000100,
        FL_COR  = 7'b0001000,
        FL_SN   = 7'b0010000,
        FL_SQ   = 7'b0100000,
        FL_DONE = 7'b1000000
    } fill_state_t;

    fill_state_t     state_reg, state_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [30:0]     th_reg, th_next;
    logic [RW-1:0]   thr_reg, thr_next;
    logic [2:0]      k_reg, k_next;
    logic [31:0]     t2_reg, t2_next;
    logic [30:0]     term_reg, term_next;
    logic [31:0]     v_reg, v_next;
    logic [29:0]     q0_reg, q0_next;
    logic [30:0]     sn_reg, sn_next;

    logic [61:0]     p_th2;
    logic [62:0]     p_t2term;
    logic [64:0]     p_rec;
    logic [32:0]     rem;
    logic [29:0]     q_fix;
    logic [61:0]     p_sn;
    logic [61:0]     p_sq;
    logic [RW-1:0]   thr_sum;

    // arithmetic of the steps
    always_comb
    begin
        p_th2    = 62'(th_reg) * 62'(th_reg);
        p_t2term = 63'(t2_reg) * 63'(term_reg);
        p_rec    = 65'(v_reg) * 65'(RECIP[k_reg]);
        rem      = {1'b0, v_reg} - 33'(q0_reg) * 33'(DENOM[k_reg]);
        q_fix    = q0_reg + 30'(rem >= 33'(DENOM[k_reg]));
        p_sn     = 62'(th_reg) * 62'(term_reg);
        p_sq     = 62'(sn_reg) * 62'(sn_reg) + SQ_ROUND;
        thr_sum  = thr_reg + TH_REM;
    end

    // step sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        th_next    = th_reg;
        thr_next   = thr_reg;
        k_next     = k_reg;
        t2_next    = t2_reg;
        term_next  = term_reg;
        v_next     = v_reg;
        q0_next    = q0_reg;
        sn_next    = sn_reg;
        we         = 1'b0;
        case (state_reg)
            FL_T2:
            begin
                t2_next    = p_th2[61:30];
                term_next  = Q30_ONE_U;
                k_next     = 3'd0;
                state_next = FL_MUL;
            end
            FL_MUL:
            begin
                v_next     = p_t2term[61:30];
                state_next = FL_REC;
            end
            FL_REC:
            begin
                q0_next    = p_rec[64:35];
                state_next = FL_COR;
            end
            FL_COR:
            begin
                term_next = Q30_ONE_U - 31'(q_fix);
                k_next    = k_reg + 3'd1;
                if (k_reg == 3'd4)
                begin
                    state_next = FL_SN;
                end
                else
                begin
                    state_next = FL_MUL;
                end
            end
            FL_SN:
            begin
                sn_next    = p_sn[60:30];
                state_next = FL_SQ;
            end
            FL_SQ:
            begin
                we = 1'b1;
                // next angle, kept as quotient and remainder
                if (thr_sum >= DEPTH_R)
                begin
                    thr_next = thr_sum - DEPTH_R;
                    th_next  = th_reg + TH_STEP + 31'd1;
                end
                else
                begin
                    thr_next = thr_sum;
                    th_next  = th_reg + TH_STEP;
                end
                idx_next = idx_reg + AW'(1);
                if (idx_reg == AW'(WEIGHT_DEPTH - 1))
                begin
                    state_next = FL_DONE;
                end
                else
                begin
                    state_next = FL_T2;
                end
            end
            FL_DONE:
            begin
                state_next = FL_DONE;
            end
            default:
            begin
                state_next = FL_DONE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FL_T2;
            idx_reg   <= '0;
            th_reg    <= '0;
            thr_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            th_reg    <= th_next;
            thr_reg   <= thr_next;
            k_reg     <= k_next;
        end
    end

    // work registers
    always_ff @(posedge clk)
    begin
        t2_reg   <= t2_next;
        term_reg <= term_next;
        v_reg    <= v_next;
        q0_reg   <= q0_next;
        sn_reg   <= sn_next;
    end

    assign waddr     = idx_reg;
    assign wdata     = p_sq[60:44];
    assign fill_done = (state_reg == FL_DONE);

endmodule

`default_nettype wire

### rtl/vn2_ctrl.sv
// sequencer for one noise sample: octave loop, hash issue, smoothing, blends
`default_nettype none

module vn2_ctrl
    import vn2_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire logic  fill_done,
    input  wire stat_t stat,
    output logic       busy,
    output cmd_t       cmd
);

    localparam logic [3:0] LAST_POINT = 4'(HASH_POINTS - 1);
    localparam logic [3:0] LAST_DRAIN = 4'd2;

    typedef enum logic [16:0] {
        ST_IDLE  = 17'b00000000000000001,
        ST_CHECK = 17'b00000000000000010,
        ST_SETUP = 17'b00000000000000100,
        ST_RDX   = 17'b00000000000001000,
        ST_RDY   = 17'b00000000000010000,
        ST_HASH  = 17'b00000000000100000,
        ST_DRAIN = 17'b00000000001000000,
        ST_SM1   = 17'b00000000010000000,
        ST_SM2   = 17'b00000000100000000,
        ST_B0A   = 17'b00000001000000000,
        ST_B0B   = 17'b00000010000000000,
        ST_B1A   = 17'b00000100000000000,
        ST_B1B   = 17'b00001000000000000,
        ST_B2A   = 17'b00010000000000000,
        ST_B2B   = 17'b00100000000000000,
        ST_ACC   = 17'b01000000000000000,
        ST_FIN   = 17'b10000000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.blend_sel = BL_TOP;
        case (state_reg)
            ST_IDLE:
            begin
                // the request is captured at the edge that accepts it
                if (start && fill_done)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = stat.more ? ST_SETUP : ST_FIN;
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_RDX;
            end
            ST_RDX:
            begin
                state_next = ST_RDY;
            end
            ST_RDY:
            begin
                cmd.rd_y   = 1'b1;
                cmd.ld_wx  = 1'b1;
                cnt_next   = '0;
                state_next = ST_HASH;
            end
            ST_HASH:
            begin
                cmd.ld_wy    = (cnt_reg == 4'd0);
                cmd.hash_vld = 1'b1;
                cmd.hash_tag = cnt_reg;
                cnt_next     = cnt_reg + 4'd1;
                if (cnt_reg == LAST_POINT)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // wait for the hash pipeline to empty
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == LAST_DRAIN)
                begin
                    state_next = ST_SM1;
                end
            end
            ST_SM1:
            begin
                cmd.smooth_row = 1'b1;
                state_next     = ST_SM2;
            end
            ST_SM2:
            begin
                cmd.smooth_col = 1'b1;
                state_next     = ST_B0A;
            end
            ST_B0A:
            begin
                cmd.blend_sel = BL_TOP;
                cmd.blend_a   = 1'b1;
                state_next    = ST_B0B;
            end
            ST_B0B:
            begin
                cmd.blend_sel = BL_TOP;
                cmd.blend_b   = 1'b1;
                state_next    = ST_B1A;
            end
            ST_B1A:
            begin
                cmd.blend_sel = BL_BOT;
                cmd.blend_a   = 1'b1;
                state_next    = ST_B1B;
            end
            ST_B1B:
            begin
                cmd.blend_sel = BL_BOT;
                cmd.blend_b   = 1'b1;
                state_next    = ST_B2A;
            end
            ST_B2A:
            begin
                cmd.blend_sel = BL_FIN;
                cmd.blend_a   = 1'b1;
                state_next    = ST_B2B;
            end
            ST_B2B:
            begin
                cmd.blend_sel = BL_FIN;
                cmd.blend_b   = 1'b1;
                state_next    = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.accum  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy = (state_reg != ST_IDLE) || !fill_done;

endmodule

`default_nettype wire

### rtl/vn2_dpath.sv
// datapath: configuration, coordinates, hash pipeline, smoothing, blends, octave sum
`default_nettype none

module vn2_dpath
    import vn2_pkg::*;
#(
    parameter int MAX_OCTAVES  = MAX_OCT_DEF,
    parameter int WEIGHT_DEPTH = WT_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [2:0]                  wr_index,
    input  wire logic [31:0]                 wr_data,
    input  wire logic [15:0]                 column,
    input  wire logic [15:0]                 row,
    input  wire cmd_t                        cmd,
    output stat_t                            stat,
    output logic [$clog2(WEIGHT_DEPTH)-1:0]  ram_raddr,
    input  wire logic [WT_W-1:0]             ram_rdata,
    output logic signed [31:0]               noise_value,
    output logic                             done
);

    localparam int AW  = $clog2(WEIGHT_DEPTH);
    localparam int S_W = $clog2(MAX_OCTAVES + 1);
    localparam int FW  = MAX_OCTAVES;
    localparam int PW  = FW + AW + 1;

    // configuration registers
    logic signed [31:0] seed_reg, shx_reg, shy_reg;
    logic [16:0]        ratio_reg;
    logic [4:0]         oct_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= '0;
            ratio_reg <= 17'd32768;
            oct_reg   <= 5'd4;
            shx_reg   <= '0;
            shy_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                CFG_SEED:   seed_reg  <= wr_data;
                CFG_RATIO:  ratio_reg <= wr_data[16:0];
                CFG_OCT:    oct_reg   <= wr_data[4:0];
                CFG_SHIFTX: shx_reg   <= wr_data;
                CFG_SHIFTY: shy_reg   <= wr_data;
                default:    ;
            endcase
        end
    end

    // clamped settings
    logic [S_W-1:0] oct_eff;
    logic [16:0]    ratio_eff;

    always_comb
    begin
        oct_eff   = (32'(oct_reg) > 32'(MAX_OCTAVES)) ? S_W'(MAX_OCTAVES) : S_W'(oct_reg);
        ratio_eff = (ratio_reg > 17'd65536) ? 17'd65536 : ratio_reg;
    end

    // sample point, octave shift, amplitude and sum
    logic signed [31:0] px_reg, py_reg;
    logic [S_W-1:0]     s_reg;
    logic [16:0]        amp_reg;
    logic [16:0]        rat_reg;
    logic signed [55:0] total_reg;

    // per-octave lattice origin and table indexes
    logic signed [31:0] ix_reg, iy_reg;
    logic [AW-1:0]      idx_x_reg, idx_y_reg;
    logic [WT_W-1:0]    wx_reg, wy_reg;

    logic [FW-1:0] mask;
    logic [FW-1:0] fx, fy;
    logic [PW-1:0] prod_x, prod_y;
    logic [PW-1:0] sidx_x, sidx_y;

    always_comb
    begin
        mask   = ~({FW{1'b1}} << s_reg);
        fx     = px_reg[FW-1:0] & mask;
        fy     = py_reg[FW-1:0] & mask;
        prod_x = PW'(fx) * PW'(WEIGHT_DEPTH);
        prod_y = PW'(fy) * PW'(WEIGHT_DEPTH);
        sidx_x = prod_x >> s_reg;
        sidx_y = prod_y >> s_reg;
    end

    // hash pipeline, one lattice point issued per cycle
    logic [31:0] hx, hy, n0, n1;
    logic        hv1_reg, hv2_reg, hv3_reg;
    logic [3:0]  ht1_reg, ht2_reg, ht3_reg;
    logic [31:0] hn1_reg, hn2_reg, hn3_reg;
    logic [31:0] hsq2_reg, hp3_reg;
    logic [31:0] m_full;
    logic signed [31:0] h_val;

    always_comb
    begin
        hx     = ix_reg + 32'(cmd.hash_tag[1:0]) - 32'd1;
        hy     = iy_reg + 32'(cmd.hash_tag[3:2]) - 32'd1;
        n0     = hx + hy * HASH_MUL_Y + seed_reg;
        n1     = n0 ^ (n0 << 13);
        m_full = hn3_reg * hp3_reg + HASH_C3;
        h_val  = Q30_ONE_S - $signed({1'b0, m_full[30:0]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv1_reg <= 1'b0;
            hv2_reg <= 1'b0;
            hv3_reg <= 1'b0;
        end
        else
        begin
            hv1_reg <= cmd.hash_vld;
            hv2_reg <= hv1_reg;
            hv3_reg <= hv2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ht1_reg  <= cmd.hash_tag;
        hn1_reg  <= n1;
        ht2_reg  <= ht1_reg;
        hn2_reg  <= hn1_reg;
        hsq2_reg <= hn1_reg * hn1_reg;
        ht3_reg  <= ht2_reg;
        hn3_reg  <= hn2_reg;
        hp3_reg  <= hsq2_reg * HASH_C1 + HASH_C2;
    end

    // 4x4 grid of hashes, rows by y
    logic signed [31:0] g_reg [HASH_POINTS];

    always_ff @(posedge clk)
    begin
        if (hv3_reg)
        begin
            g_reg[ht3_reg] <= h_val;
        end
    end

    // separable 1-2-1 smoothing: rows first, then columns
    logic signed [33:0] rs_reg [4][2];
    logic signed [35:0] sm_reg [2][2];

    always_ff @(posedge clk)
    begin
        if (cmd.smooth_row)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 2; c++)
                begin
                    rs_reg[r][c] <= 34'(g_reg[r*4+c]) + (34'(g_reg[r*4+c+1]) <<< 1)
                                  + 34'(g_reg[r*4+c+2]);
                end
            end
        end
        if (cmd.smooth_col)
        begin
            for (int j = 0; j < 2; j++)
            begin
                for (int c = 0; c < 2; c++)
                begin
                    sm_reg[j][c] <= 36'(rs_reg[j][c]) + (36'(rs_reg[j+1][c]) <<< 1)
                                  + 36'(rs_reg[j+2][c]);
                end
            end
        end
    end

    // shared blend unit: a*(1-w) then + b*w, floor shift by 16
    logic signed [35:0] top_reg, bot_reg, fin_reg;
    logic signed [54:0] bacc_reg;
    logic signed [35:0] bl_a, bl_b;
    logic [WT_W-1:0]    bl_w;
    logic signed [17:0] w_lo, w_hi;
    logic signed [53:0] bl_prod;
    logic signed [54:0] bl_sum;
    logic signed [35:0] bl_res;

    always_comb
    begin
        case (cmd.blend_sel)
            BL_TOP:
            begin
                bl_a = sm_reg[0][0];
                bl_b = sm_reg[0][1];
                bl_w = wx_reg;
            end
            BL_BOT:
            begin
                bl_a = sm_reg[1][0];
                bl_b = sm_reg[1][1];
                bl_w = wx_reg;
            end
            BL_FIN:
            begin
                bl_a = top_reg;
                bl_b = bot_reg;
                bl_w = wy_reg;
            end
            default:
            begin
                bl_a = top_reg;
                bl_b = bot_reg;
                bl_w = wy_reg;
            end
        endcase
        w_hi    = $signed({1'b0, bl_w});
        w_lo    = 18'sd65536 - w_hi;
        bl_prod = cmd.blend_a ? (bl_a * w_lo) : (bl_b * w_hi);
        bl_sum  = bacc_reg + 55'(bl_prod);
        bl_res  = bl_sum[51:16];
    end

    // octave sum and amplitude update
    logic signed [53:0] acc_prod;
    logic [33:0]        amp_prod;

    always_comb
    begin
        acc_prod = fin_reg * $signed({1'b0, amp_reg});
        amp_prod = 34'(amp_reg) * 34'(rat_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg    <= 32'(column) + shx_reg;
            py_reg    <= 32'(row) + shy_reg;
            s_reg     <= oct_eff;
            amp_reg   <= 17'd65536;
            rat_reg   <= ratio_eff;
            total_reg <= '0;
        end
        if (cmd.setup)
        begin
            ix_reg    <= px_reg >>> s_reg;
            iy_reg    <= py_reg >>> s_reg;
            idx_x_reg <= sidx_x[AW-1:0];
            idx_y_reg <= sidx_y[AW-1:0];
        end
        if (cmd.ld_wx)
        begin
            wx_reg <= ram_rdata;
        end
        if (cmd.ld_wy)
        begin
            wy_reg <= ram_rdata;
        end
        if (cmd.blend_a)
        begin
            bacc_reg <= 55'(bl_prod);
        end
        if (cmd.blend_b)
        begin
            case (cmd.blend_sel)
                BL_TOP:  top_reg <= bl_res;
                BL_BOT:  bot_reg <= bl_res;
                BL_FIN:  fin_reg <= bl_res;
                default: fin_reg <= bl_res;
            endcase
        end
        if (cmd.accum)
        begin
            total_reg <= total_reg + 56'(acc_prod);
            amp_reg   <= amp_prod[32:16];
            s_reg     <= s_reg - S_W'(1);
        end
    end

    // result register; the 56-bit sum shifted by 24 always fits 32 bits
    logic signed [31:0] res_reg;
    logic               done_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_reg <= total_reg[55:24];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    assign stat.more   = (s_reg >= S_W'(2));
    assign ram_raddr   = cmd.rd_y ? idx_y_reg : idx_x_reg;
    assign noise_value = res_reg;
    assign done        = done_reg;

endmodule

`default_nettype wire

### rtl/value_noise_2d_octaves_top.sv
// fractal 2-d value noise, n = min(octave_count, MAX_OCTAVES) - 1 octaves (0 if none):
// one sample at a time, each octave set by 16 hashes through a multiply pipeline and
// 6 blend steps. the result shows on noise_value with a one-cycle done strobe and is
// held until the next result; the receiver cannot stall. after reset the weight table
// is built one entry at a time with busy high; configuration writes are taken at any
// time.
`default_nettype none

module value_noise_2d_octaves_top
    import vn2_pkg::*;
#(
    parameter int MAX_OCTAVES        = MAX_OCT_DEF,
    parameter int WEIGHT_TABLE_DEPTH = WT_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [15:0]        column,
    input  wire logic [15:0]        row,
    input  wire logic               wr_en,
    input  wire logic [2:0]         wr_index,
    input  wire logic [31:0]        wr_data,
    output logic                    done,
    output logic signed [31:0]      noise_value
);

    localparam int AW = $clog2(WEIGHT_TABLE_DEPTH);

    cmd_t            cmd;
    stat_t           stat;
    logic            fill_done;
    logic            tab_we;
    logic [AW-1:0]   tab_waddr;
    logic [AW-1:0]   tab_raddr;
    logic [WT_W-1:0] tab_wdata;
    logic [WT_W-1:0] tab_rdata;

    // weight table builder
    vn2_wtab_fill #(
        .WEIGHT_DEPTH (WEIGHT_TABLE_DEPTH)
    ) u_fill (
        .clk       (clk),
        .rst_n     (rst_n),
        .we        (tab_we),
        .waddr     (tab_waddr),
        .wdata     (tab_wdata),
        .fill_done (fill_done)
    );

    // weight table storage
    vn2_ram #(
        .WIDTH (WT_W),
        .DEPTH (WEIGHT_TABLE_DEPTH)
    ) u_wtab (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    // sequencer
    vn2_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .fill_done (fill_done),
        .stat      (stat),
        .busy      (busy),
        .cmd       (cmd)
    );

    // datapath
    vn2_dpath #(
        .MAX_OCTAVES  (MAX_OCTAVES),
        .WEIGHT_DEPTH (WEIGHT_TABLE_DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .column      (column),
        .row         (row),
        .cmd         (cmd),
        .stat        (stat),
        .ram_raddr   (tab_raddr),
        .ram_rdata   (tab_rdata),
        .noise_value (noise_value),
        .done        (done)
    );

endmodule

`default_nettype wire

### test/tb_value_noise_2d_octaves_top.sv
// self-checking testbench for the fractal value noise block
`timescale 1ns / 100ps
`default_nettype none

module tb_value_noise_2d_octaves_top;
    import vn2_pkg::*;

    localparam int MAX_OCT    = MAX_OCT_DEF;
    localparam int WT_DEPTH   = WT_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [2:0] BAD_INDEX_LO = 3'd5;
    localparam logic [2:0] BAD_INDEX_HI = 3'd7;
    localparam longint unsigned Q30_UNIT = 64'd1073741824;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [15:0]        column;
    logic [15:0]        row;
    logic               wr_en;
    logic [2:0]         wr_index;
    logic [31:0]        wr_data;
    logic               done;
    logic signed [31:0] noise_value;

    // local copy of the block's registers and weight table
    logic [31:0] seed_q;
    logic [16:0] ratio_q;
    logic [4:0]  oct_q;
    logic [31:0] shift_x_q;
    logic [31:0] shift_y_q;
    logic [16:0] weight_lut [WT_DEPTH];

    logic signed [31:0] noise_expected [$];
    int  cycle_count;
    int  mismatch_count;
    int  request_count;
    int  result_count;
    int  config_count;
    bit  no_gaps;

    value_noise_2d_octaves_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .column      (column),
        .row         (row),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .done        (done),
        .noise_value (noise_value)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // sin^2 weight entry from the fixed taylor series
    function automatic logic [16:0] weight_entry(int unsigned idx);
        longint unsigned th;
        longint unsigned t2;
        longint unsigned term;
        longint unsigned sn;
        longint unsigned denoms [5];
        denoms = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
        th = (64'd1686629713 * 64'(idx)) / 64'(WT_DEPTH);
        t2 = (th * th) >> 30;
        term = Q30_UNIT;
        for (int k = 0; k < 5; k++)
        begin
            term = Q30_UNIT - (((t2 * term) >> 30) / denoms[k]);
        end
        sn = (th * term) >> 30;
        return 17'((sn * sn + (64'd1 << 43)) >> 44);
    endfunction

    // seeded lattice hash, q2.30
    function automatic longint lattice_hash(logic [31:0] x, logic [31:0] y);
        logic [31:0] n;
        logic [31:0] m;
        n = x + y * 32'd57 + seed_q;
        n = (n << 13) ^ n;
        m = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7FFF_FFFF;
        return longint'(Q30_UNIT) - longint'({32'd0, m});
    endfunction

    // 3x3 smoothing, 34 fraction bits
    function automatic longint smoothed_hash(logic [31:0] x, logic [31:0] y);
        longint corners;
        longint sides;
        corners = lattice_hash(x - 1, y - 1) + lattice_hash(x + 1, y - 1)
                + lattice_hash(x - 1, y + 1) + lattice_hash(x + 1, y + 1);
        sides = lattice_hash(x - 1, y) + lattice_hash(x + 1, y)
              + lattice_hash(x, y - 1) + lattice_hash(x, y + 1);
        return corners + 2 * sides + 4 * lattice_hash(x, y);
    endfunction

    function automatic longint cosine_blend(longint a, longint b, logic [16:0] w);
        return (a * (longint'(65536) - longint'(w)) + b * longint'(w)) >>> 16;
    endfunction

    function automatic logic [16:0] weight_of(logic [31:0] frac, int s);
        longint unsigned idx;
        idx = (64'(frac) * 64'(WT_DEPTH)) >> s;
        if (idx >= 64'(WT_DEPTH))
            idx = 64'(WT_DEPTH - 1);
        return weight_lut[idx];
    endfunction

    // expected noise sample for one coordinate pair
    function automatic logic signed [31:0] predict_noise(logic [15:0] col, logic [15:0] rw);
        logic [31:0] px32;
        logic [31:0] py32;
        longint px;
        longint py;
        int oct;
        longint unsigned ratio;
        longint unsigned amp;
        longint total;
        longint res;
        int s;
        logic [31:0] mask;
        logic [31:0] ix;
        logic [31:0] iy;
        logic [16:0] wx;
        logic [16:0] wy;
        longint top_v;
        longint bot_v;
        px32 = {16'd0, col} + shift_x_q;
        py32 = {16'd0, rw} + shift_y_q;
        px = longint'(signed'(px32));
        py = longint'(signed'(py32));
        oct = (oct_q > MAX_OCT) ? MAX_OCT : int'(oct_q);
        ratio = (ratio_q > 17'd65536) ? 64'd65536 : 64'(ratio_q);
        amp = 64'd65536;
        total = 0;
        for (int k = 1; k < oct; k++)
        begin
            s = oct + 1 - k;
            mask = (32'd1 << s) - 32'd1;
            ix = 32'(px >>> s);
            iy = 32'(py >>> s);
            wx = weight_of(px32 & mask, s);
            wy = weight_of(py32 & mask, s);
            top_v = cosine_blend(smoothed_hash(ix, iy), smoothed_hash(ix + 1, iy), wx);
            bot_v = cosine_blend(smoothed_hash(ix, iy + 1), smoothed_hash(ix + 1, iy + 1), wx);
            total += cosine_blend(top_v, bot_v, wy) * longint'(amp);
            amp = (amp * ratio) >> 16;
        end
        res = total >>> 24;
        if (res > 64'sd2147483647)
            res = 64'sd2147483647;
        if (res < -64'sd2147483648)
            res = -64'sd2147483648;
        return 32'(res);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            result_count++;
            if (noise_expected.size() == 0)
                report_mismatch("unexpected result", noise_value, 32'd0);
            else if (noise_value !== noise_expected[0])
            begin
                report_mismatch("noise_value", noise_value, noise_expected[0]);
                void'(noise_expected.pop_front());
            end
            else
                void'(noise_expected.pop_front());
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one request, caller sits at a falling edge
    task automatic send_request(logic [15:0] col, logic [15:0] rw);
        start = 1'b1;
        column = col;
        row = rw;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        noise_expected.push_back(predict_noise(col, rw));
        request_count++;
        @(negedge clk);
        start = 1'b0;
        repeat (pick_gap()) @(negedge clk);
    endtask

    // block idle: nothing pending and nothing in flight
    task automatic wait_idle();
        while (noise_expected.size() != 0)
            @(negedge clk);
        while (busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        wr_en = 1'b1;
        wr_index = idx;
        wr_data = value;
        @(negedge clk);
        wr_en = 1'b0;
        config_count++;
        case (idx)
            CFG_SEED:   seed_q = value;
            CFG_RATIO:  ratio_q = value[16:0];
            CFG_OCT:    oct_q = value[4:0];
            CFG_SHIFTX: shift_x_q = value;
            CFG_SHIFTY: shift_y_q = value;
            default: ;
        endcase
    endtask

    task automatic set_all(logic [31:0] seed, logic [31:0] ratio, logic [31:0] oct,
                           logic [31:0] sx, logic [31:0] sy);
        wait_idle();
        write_reg(CFG_SEED, seed);
        write_reg(CFG_RATIO, ratio);
        write_reg(CFG_OCT, oct);
        write_reg(CFG_SHIFTX, sx);
        write_reg(CFG_SHIFTY, sy);
    endtask

    // defaults after reset, coordinate extremes
    task automatic test_reset_defaults();
        send_request(16'h0000, 16'h0000);
        send_request(16'hFFFF, 16'hFFFF);
        send_request(16'hAAAA, 16'h5555);
        send_request(16'h5555, 16'hAAAA);
    endtask

    // octave counts at and beyond the edges
    task automatic test_octave_edges();
        set_all(32'd0, 32'd32768, 32'd0, 32'd0, 32'd0);
        send_request(16'h1234, 16'h4321);
        set_all(32'd0, 32'd32768, 32'd1, 32'd0, 32'd0);
        send_request(16'hFFFF, 16'h0001);
        set_all(32'd7, 32'd65536, 32'd2, 32'd0, 32'd0);
        send_request(16'h0003, 16'h0002);
        set_all(32'd7, 32'd65536, 32'd16, 32'd0, 32'd0);
        send_request(16'hFFFF, 16'hFFFF);
        set_all(32'd7, 32'd65536, 32'd31, 32'd0, 32'd0);
        send_request(16'h8000, 16'h7FFF);
    endtask

    // ratio extremes, including above one
    task automatic test_ratio_edges();
        set_all(32'h8000_0000, 32'd0, 32'd5, 32'd0, 32'd0);
        send_request(16'h0F0F, 16'hF0F0);
        set_all(32'h7FFF_FFFF, 32'h0001_FFFF, 32'd5, 32'd0, 32'd0);
        send_request(16'h0F0F, 16'hF0F0);
        set_all(32'hFFFF_FFFF, 32'd65537, 32'd6, 32'd0, 32'd0);
        send_request(16'h0100, 16'h0200);
    endtask

    // offsets that wrap the coordinate, negative coordinates
    task automatic test_coordinate_wrap();
        set_all(32'd1, 32'd40000, 32'd6, 32'h7FFF_FFFF, 32'h7FFF_FFF0);
        send_request(16'hFFFF, 16'h0010);
        send_request(16'h0000, 16'hFFFF);
        set_all(32'd1, 32'd40000, 32'd6, 32'h8000_0000, 32'hFFFF_0000);
        send_request(16'h0000, 16'h0000);
        send_request(16'hFFFF, 16'hFFFF);
    endtask

    // writes to unused indexes must be ignored
    task automatic test_bad_index();
        wait_idle();
        write_reg(BAD_INDEX_LO, 32'hFFFF_FFFF);
        write_reg(BAD_INDEX_HI, 32'h0000_0001);
        send_request(16'h4444, 16'h2222);
        send_request(16'h0001, 16'h8000);
    endtask

    // random phases, each with a fresh register setting
    task automatic test_random_phases();
        logic [31:0] oct;
        logic [31:0] ratio;
        int n_items;
        for (int phase = 0; phase < 26; phase++)
        begin
            case ($urandom_range(0, 9))
                0:       oct = $urandom_range(0, 31);
                1:       oct = MAX_OCT;
                default: oct = $urandom_range(2, 6);
            endcase
            ratio = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                  : $urandom_range(0, 65536);
            set_all($urandom(), ratio, oct, $urandom(),
                    ($urandom_range(0, 1) == 1) ? $urandom() : $urandom_range(0, 255));
            no_gaps = (phase % 5 == 2);
            n_items = (oct >= 10 && oct != 31) ? 15 : 55;
            for (int i = 0; i < n_items; i++)
                send_request(16'($urandom()), 16'($urandom()));
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        clk = 1'b1;
        rst_n = 1'b0;
        start = 1'b0;
        column = 16'd0;
        row = 16'd0;
        wr_en = 1'b0;
        wr_index = 3'd0;
        wr_data = 32'd0;
        cycle_count = 0;
        mismatch_count = 0;
        request_count = 0;
        result_count = 0;
        config_count = 0;
        no_gaps = 1'b0;
        seed_q = 32'd0;
        ratio_q = 17'd32768;
        oct_q = 5'd4;
        shift_x_q = 32'd0;
        shift_y_q = 32'd0;
        for (int i = 0; i < WT_DEPTH; i++)
            weight_lut[i] = weight_entry(i);

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_octave_edges();
        test_ratio_edges();
        test_coordinate_wrap();
        test_bad_index();
        test_random_phases();

        // drain
        while (noise_expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d requests, %0d results, %0d register writes, %0d mismatches",
                 request_count, result_count, config_count, mismatch_count);
        $display("covered octave, ratio, seed and offset extremes plus random phases");
        if (mismatch_count == 0 && noise_expected.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/vn2_pkg.sv
rtl/vn2_ram.sv
rtl/vn2_wtab_fill.sv
rtl/vn2_ctrl.sv
rtl/vn2_dpath.sv
rtl/value_noise_2d_octaves_top.sv
test/tb_value_noise_2d_octaves_top.sv
